// ----- hdl/la_pkg.sv -----
// Package for the lottery arbiter: constants, codes, state type and random table.
`default_nettype none
package la_pkg;
  localparam int Entries = 64;
  localparam int SlotW = 6;
  localparam int IdxW = 7;
  localparam int TicketW = 10;
  localparam int SumW = 16;
  localparam int RandW = 17;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_DRAW = 2'd2;

  localparam logic [2:0] ST_UNUSED = 3'd0;
  localparam logic [2:0] ST_EMBRYO = 3'd1;
  localparam logic [2:0] ST_RUNNABLE = 3'd3;
  localparam logic [2:0] ST_RUNNING = 3'd4;

  localparam logic [9:0] TicketMod = 10'd1000;

  typedef enum logic [3:0] {
    S_IDLE, S_ALLOC_SCAN, S_ALLOC_RD, S_ALLOC_MOD, S_SUM, S_DRAW_MOD,
    S_PICK, S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic [RandW-1:0] dividend;
    logic [RandW-1:0] divisor;
  } mod_req_t;

  function automatic logic [RandW-1:0] rand_value(input logic [7:0] idx);
    logic [RandW-1:0] v;
    case (idx)
      8'd0: v = 17'd77183; 8'd1: v = 17'd76065; 8'd2: v = 17'd29273;
      8'd3: v = 17'd98963; 8'd4: v = 17'd23453; 8'd5: v = 17'd69495;
      8'd6: v = 17'd91613; 8'd7: v = 17'd90129; 8'd8: v = 17'd61763;
      8'd9: v = 17'd78537; 8'd10: v = 17'd54549; 8'd11: v = 17'd19663;
      8'd12: v = 17'd63559; 8'd13: v = 17'd84421; 8'd14: v = 17'd31533;
      8'd15: v = 17'd48915; 8'd16: v = 17'd88915; 8'd17: v = 17'd85721;
      8'd18: v = 17'd48003; 8'd19: v = 17'd91645; 8'd20: v = 17'd96659;
      8'd21: v = 17'd28171; 8'd22: v = 17'd76119; 8'd23: v = 17'd95383;
      8'd24: v = 17'd21329; 8'd25: v = 17'd76995; 8'd26: v = 17'd57509;
      8'd27: v = 17'd46521; 8'd28: v = 17'd63693; 8'd29: v = 17'd72709;
      8'd30: v = 17'd50221; 8'd31: v = 17'd93225; 8'd32: v = 17'd41819;
      8'd33: v = 17'd43485; 8'd34: v = 17'd39707; 8'd35: v = 17'd88343;
      8'd36: v = 17'd59521; 8'd37: v = 17'd74955; 8'd38: v = 17'd97349;
      8'd39: v = 17'd12585; 8'd40: v = 17'd27551; 8'd41: v = 17'd96485;
      8'd42: v = 17'd72659; 8'd43: v = 17'd84179; 8'd44: v = 17'd69751;
      8'd45: v = 17'd88721; 8'd46: v = 17'd46957; 8'd47: v = 17'd64935;
      8'd48: v = 17'd77531; 8'd49: v = 17'd14181; 8'd50: v = 17'd14393;
      8'd51: v = 17'd22947; 8'd52: v = 17'd15145; 8'd53: v = 17'd55103;
      8'd54: v = 17'd62621; 8'd55: v = 17'd14067; 8'd56: v = 17'd56755;
      8'd57: v = 17'd60365; 8'd58: v = 17'd26261; 8'd59: v = 17'd76139;
      8'd60: v = 17'd98923; 8'd61: v = 17'd55949; 8'd62: v = 17'd11043;
      8'd63: v = 17'd85645; 8'd64: v = 17'd21421; 8'd65: v = 17'd56107;
      8'd66: v = 17'd91887; 8'd67: v = 17'd60493; 8'd68: v = 17'd81231;
      8'd69: v = 17'd10897; 8'd70: v = 17'd49729; 8'd71: v = 17'd25621;
      8'd72: v = 17'd92319; 8'd73: v = 17'd57811; 8'd74: v = 17'd14025;
      8'd75: v = 17'd73073; 8'd76: v = 17'd79999; 8'd77: v = 17'd99485;
      8'd78: v = 17'd10801; 8'd79: v = 17'd95165; 8'd80: v = 17'd46447;
      8'd81: v = 17'd81625; 8'd82: v = 17'd97585; 8'd83: v = 17'd41537;
      8'd84: v = 17'd18995; 8'd85: v = 17'd20235; 8'd86: v = 17'd13011;
      8'd87: v = 17'd46941; 8'd88: v = 17'd82823; 8'd89: v = 17'd17511;
      8'd90: v = 17'd52337; 8'd91: v = 17'd59047; 8'd92: v = 17'd20331;
      8'd93: v = 17'd77675; 8'd94: v = 17'd71707; 8'd95: v = 17'd59067;
      8'd96: v = 17'd96099; 8'd97: v = 17'd59683; 8'd98: v = 17'd17659;
      8'd99: v = 17'd20377; 8'd100: v = 17'd37277; 8'd101: v = 17'd58869;
      8'd102: v = 17'd21223; 8'd103: v = 17'd41745; 8'd104: v = 17'd15797;
      8'd105: v = 17'd61967; 8'd106: v = 17'd49795; 8'd107: v = 17'd77755;
      8'd108: v = 17'd57365; 8'd109: v = 17'd45683; 8'd110: v = 17'd34327;
      8'd111: v = 17'd51289; 8'd112: v = 17'd74821; 8'd113: v = 17'd43041;
      8'd114: v = 17'd48941; 8'd115: v = 17'd48321; 8'd116: v = 17'd59185;
      8'd117: v = 17'd93299; 8'd118: v = 17'd64111; 8'd119: v = 17'd76447;
      8'd120: v = 17'd83317; 8'd121: v = 17'd76041; 8'd122: v = 17'd74969;
      8'd123: v = 17'd77723; 8'd124: v = 17'd28433; 8'd125: v = 17'd16419;
      8'd126: v = 17'd49139; 8'd127: v = 17'd61469; 8'd128: v = 17'd15805;
      8'd129: v = 17'd18565; 8'd130: v = 17'd74683; 8'd131: v = 17'd37623;
      8'd132: v = 17'd70241; 8'd133: v = 17'd54413; 8'd134: v = 17'd57685;
      8'd135: v = 17'd60499; 8'd136: v = 17'd57719; 8'd137: v = 17'd21663;
      8'd138: v = 17'd26397; 8'd139: v = 17'd60711; 8'd140: v = 17'd63027;
      8'd141: v = 17'd37169; 8'd142: v = 17'd12881; 8'd143: v = 17'd14351;
      8'd144: v = 17'd56951; 8'd145: v = 17'd44769; 8'd146: v = 17'd36645;
      8'd147: v = 17'd15041; 8'd148: v = 17'd89045; 8'd149: v = 17'd55365;
      8'd150: v = 17'd42105; 8'd151: v = 17'd61441; 8'd152: v = 17'd84759;
      8'd153: v = 17'd35905; 8'd154: v = 17'd36387; 8'd155: v = 17'd33889;
      8'd156: v = 17'd92309; 8'd157: v = 17'd13127; 8'd158: v = 17'd37387;
      8'd159: v = 17'd40757; 8'd160: v = 17'd41559; 8'd161: v = 17'd90117;
      8'd162: v = 17'd48335; 8'd163: v = 17'd48323; 8'd164: v = 17'd58459;
      8'd165: v = 17'd12407; 8'd166: v = 17'd16291; 8'd167: v = 17'd37787;
      8'd168: v = 17'd81875; 8'd169: v = 17'd54551; 8'd170: v = 17'd32429;
      8'd171: v = 17'd90811; 8'd172: v = 17'd39947; 8'd173: v = 17'd55061;
      8'd174: v = 17'd35975; 8'd175: v = 17'd27047; 8'd176: v = 17'd45165;
      8'd177: v = 17'd41179; 8'd178: v = 17'd77599; 8'd179: v = 17'd39609;
      8'd180: v = 17'd71883; 8'd181: v = 17'd37115; 8'd182: v = 17'd63123;
      8'd183: v = 17'd74125; 8'd184: v = 17'd78611; 8'd185: v = 17'd73815;
      8'd186: v = 17'd80667; 8'd187: v = 17'd95549; 8'd188: v = 17'd32127;
      8'd189: v = 17'd65197; 8'd190: v = 17'd49473; 8'd191: v = 17'd65559;
      8'd192: v = 17'd28665; 8'd193: v = 17'd98671; 8'd194: v = 17'd83931;
      8'd195: v = 17'd33423; 8'd196: v = 17'd16477; 8'd197: v = 17'd46371;
      8'd198: v = 17'd49809; 8'd199: v = 17'd34965; 8'd200: v = 17'd53245;
      8'd201: v = 17'd63397; 8'd202: v = 17'd74349; 8'd203: v = 17'd64209;
      8'd204: v = 17'd44081; 8'd205: v = 17'd52731; 8'd206: v = 17'd60585;
      8'd207: v = 17'd15227; 8'd208: v = 17'd12127; 8'd209: v = 17'd55539;
      8'd210: v = 17'd27691; 8'd211: v = 17'd69883; 8'd212: v = 17'd34843;
      8'd213: v = 17'd19371; 8'd214: v = 17'd19845; 8'd215: v = 17'd35609;
      8'd216: v = 17'd70645; 8'd217: v = 17'd38567; 8'd218: v = 17'd19657;
      8'd219: v = 17'd75873; 8'd220: v = 17'd60035; 8'd221: v = 17'd50943;
      8'd222: v = 17'd44361; 8'd223: v = 17'd51131; 8'd224: v = 17'd58793;
      8'd225: v = 17'd21503; 8'd226: v = 17'd92223; 8'd227: v = 17'd72827;
      8'd228: v = 17'd88403; 8'd229: v = 17'd55861; 8'd230: v = 17'd45879;
      8'd231: v = 17'd44221; 8'd232: v = 17'd47009; 8'd233: v = 17'd28237;
      8'd234: v = 17'd27983; 8'd235: v = 17'd98089; 8'd236: v = 17'd90031;
      8'd237: v = 17'd95905; 8'd238: v = 17'd82645; 8'd239: v = 17'd89687;
      8'd240: v = 17'd78307; 8'd241: v = 17'd45551; 8'd242: v = 17'd74757;
      8'd243: v = 17'd38401; 8'd244: v = 17'd65013; 8'd245: v = 17'd73407;
      8'd246: v = 17'd83529; 8'd247: v = 17'd11557; 8'd248: v = 17'd59967;
      8'd249: v = 17'd97373; 8'd250: v = 17'd40647; 8'd251: v = 17'd52975;
      8'd252: v = 17'd86875; 8'd253: v = 17'd87085; 8'd254: v = 17'd77925;
      default: v = 17'd81353;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// ----- hdl/lottery_arbiter.sv -----
// Lottery arbiter top level: slot table, scan sequencer and result register.
// Usage: one transaction on the input channel (opcode, slot, new_status)
// gives exactly one result transaction (found, chosen_slot, ticket_total,
// winning_number). The block takes one transaction at a time; stall is high
// from acceptance until the result has been taken.
// A status write offers its result in the cycle after acceptance. An allocate
// scans slots one per cycle up to the first unused one (at most 64) and, if one
// is found, runs the 17-step modulo unit on a random value. A draw scans all 64
// slots to sum the tickets of runnable slots, runs the modulo unit, then scans
// again up to the winner (at most 64). The slot scan goes through the
// registered table read port; the modulo unit is bit-serial.
// Reset clears every slot to unused with zero tickets and the random
// pointer to zero, through a valid bit per slot, so no clearing pass.
// A stalled result holds in the output register until taken.
`default_nettype none
module lottery_arbiter (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [1:0] opcode,
  input  wire logic [5:0] slot,
  input  wire logic [2:0] new_status,
  output logic out_valid,
  input  wire logic out_stall,
  output logic found,
  output logic [5:0] chosen_slot,
  output logic [15:0] ticket_total,
  output logic [15:0] winning_number
);
  la_pkg::state_t state, state_next;
  logic [2:0] status [la_pkg::Entries];
  logic [la_pkg::TicketW-1:0] tickets [la_pkg::Entries];
  logic [la_pkg::Entries-1:0] valid_bits;
  logic [7:0] random_pointer;
  logic [la_pkg::SlotW-1:0] idx;
  logic [la_pkg::SlotW-1:0] pos;
  logic [2:0] rd_st;
  logic [la_pkg::TicketW-1:0] rd_tk;
  logic rd_ok;
  logic [la_pkg::SumW-1:0] run;
  logic mod_busy;
  logic mod_go;
  logic [la_pkg::RandW-1:0] mod_rem;
  la_pkg::mod_req_t req;
  logic [2:0] cur_st;
  logic [la_pkg::TicketW-1:0] cur_tk;
  logic at_end;
  logic [la_pkg::SumW-1:0] run_sum;

  assign cur_st = rd_ok ? rd_st : la_pkg::ST_UNUSED;
  assign cur_tk = rd_ok ? rd_tk : '0;
  assign at_end = (pos == la_pkg::SlotW'(la_pkg::Entries - 1));
  assign run_sum = run + la_pkg::SumW'(cur_tk);
  assign mod_go = (state == la_pkg::S_ALLOC_SCAN && cur_st == la_pkg::ST_UNUSED) ||
                  (state == la_pkg::S_SUM && at_end);

  la_mod u_mod (.clk(clk), .rst(rst), .req(req), .busy(mod_busy), .rem(mod_rem));

  // table read port: data for slot pos is registered, valid in the cycle after idx
  always_ff @(posedge clk) begin
    rd_st <= status[idx];
    rd_tk <= tickets[idx];
    rd_ok <= valid_bits[idx];
    pos <= idx;
  end

  always_comb begin
    state_next = state;
    case (state)
      la_pkg::S_IDLE:
        if (in_valid) begin
          case (opcode)
            la_pkg::OP_ALLOC: state_next = la_pkg::S_ALLOC_SCAN;
            la_pkg::OP_DRAW: state_next = la_pkg::S_SUM;
            default: state_next = la_pkg::S_DONE;
          endcase
        end
      la_pkg::S_ALLOC_SCAN:
        if (cur_st == la_pkg::ST_UNUSED) state_next = la_pkg::S_ALLOC_RD;
        else if (at_end) state_next = la_pkg::S_DONE;
      la_pkg::S_ALLOC_RD: state_next = la_pkg::S_ALLOC_MOD;
      la_pkg::S_ALLOC_MOD: if (!mod_busy) state_next = la_pkg::S_DONE;
      la_pkg::S_SUM: if (at_end) state_next = la_pkg::S_DRAW_MOD;
      la_pkg::S_DRAW_MOD: if (!mod_busy && !req.start) state_next = la_pkg::S_PICK;
      la_pkg::S_PICK:
        if ((cur_st == la_pkg::ST_RUNNABLE && run_sum >= winning_number) || at_end)
          state_next = la_pkg::S_DONE;
      la_pkg::S_DONE: if (!out_stall) state_next = la_pkg::S_IDLE;
      default: state_next = la_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != la_pkg::S_IDLE);
    out_valid = (state == la_pkg::S_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= la_pkg::S_IDLE;
      valid_bits <= '0;
      random_pointer <= '0;
      idx <= '0;
      req.start <= 1'b0;
    end else begin
      state <= state_next;
      req.start <= mod_go;
      case (state)
        la_pkg::S_IDLE:
          if (in_valid) begin
            idx <= la_pkg::SlotW'(1);
            run <= '0;
            found <= 1'b0;
            chosen_slot <= '0;
            ticket_total <= '0;
            winning_number <= '0;
            if (opcode == la_pkg::OP_WRITE) begin
              status[slot] <= new_status;
              if (!valid_bits[slot]) tickets[slot] <= '0;
              valid_bits[slot] <= 1'b1;
            end
          end
        la_pkg::S_ALLOC_SCAN:
          if (cur_st == la_pkg::ST_UNUSED) begin
            req.dividend <= la_pkg::rand_value(random_pointer);
            req.divisor <= la_pkg::RandW'(la_pkg::TicketMod);
            random_pointer <= random_pointer + 8'd1;
            found <= 1'b1;
            chosen_slot <= pos;
          end else begin
            idx <= idx + la_pkg::SlotW'(1);
          end
        la_pkg::S_ALLOC_MOD:
          if (!mod_busy) begin
            status[chosen_slot] <= la_pkg::ST_EMBRYO;
            tickets[chosen_slot] <= mod_rem[la_pkg::TicketW-1:0];
            valid_bits[chosen_slot] <= 1'b1;
          end
        la_pkg::S_SUM: begin
          if (cur_st == la_pkg::ST_RUNNABLE) run <= run_sum;
          if (at_end) begin
            idx <= '0;
            req.dividend <= la_pkg::rand_value(random_pointer);
            req.divisor <= la_pkg::RandW'(
              (cur_st == la_pkg::ST_RUNNABLE ? run_sum : run)) + la_pkg::RandW'(1);
            ticket_total <= (cur_st == la_pkg::ST_RUNNABLE) ? run_sum : run;
            random_pointer <= random_pointer + 8'd1;
          end else begin
            idx <= idx + la_pkg::SlotW'(1);
          end
        end
        la_pkg::S_DRAW_MOD:
          if (!mod_busy && !req.start) begin
            winning_number <= mod_rem[la_pkg::SumW-1:0];
            idx <= la_pkg::SlotW'(1);
            run <= '0;
          end
        la_pkg::S_PICK: begin
          idx <= idx + la_pkg::SlotW'(1);
          if (cur_st == la_pkg::ST_RUNNABLE) begin
            run <= run_sum;
            if (run_sum >= winning_number) begin
              status[pos] <= la_pkg::ST_RUNNING;
              found <= 1'b1;
              chosen_slot <= pos;
            end
          end
        end
        la_pkg::S_DONE:
          if (!out_stall) idx <= '0;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hdl/la_mod.sv -----
// Restoring modulo unit, one quotient bit per cycle.
`default_nettype none
module la_mod (
  input  wire logic clk,
  input  wire logic rst,
  input  wire la_pkg::mod_req_t req,
  output logic busy,
  output logic [la_pkg::RandW-1:0] rem
);
  logic [la_pkg::RandW-1:0] quo;
  logic [la_pkg::RandW-1:0] div;
  logic [4:0] cnt;
  logic [la_pkg::RandW:0] trial;

  assign trial = {rem, quo[la_pkg::RandW-1]} - {1'b0, div};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= 5'(la_pkg::RandW);
      quo <= req.dividend;
      div <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[la_pkg::RandW-2:0], 1'b0};
      if (!trial[la_pkg::RandW]) begin
        rem <= trial[la_pkg::RandW-1:0];
      end else begin
        rem <= {rem[la_pkg::RandW-2:0], quo[la_pkg::RandW-1]};
      end
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire
